/* rtl/ocp_pkg.sv */
// Shared types, constants and tables for the conic orbit position core.
package ocp_pkg;

  localparam int CORDIC_STEPS = 18;

  // CORDIC datapath width: Q2.30 values with headroom
  localparam int CW    = 34;
  localparam int NUMW  = 38;  // a*(1-e^2), Q6.32
  localparam int DENW  = 32;  // 1+e*cos, Q.30
  localparam int QBITS = 38;  // radius, Q.16
  localparam int REMW  = NUMW + 14;
  localparam int SHW   = DENW + QBITS - 1;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [70:0] OUT_MAX = 71'sd8388607;
  localparam logic signed [70:0] OUT_MIN = -71'sd8388608;

  localparam logic [31:0] ATAN_TURNS [30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [2:0] {
    REG_SMA   = 3'd0,
    REG_ECC   = 3'd1,
    REG_RATE  = 3'd2,
    REG_ANGLE = 3'd3,
    REG_START = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [21:0] sma;
    logic [15:0] ecc;
    logic [23:0] rate;
    logic [18:0] angle;
    logic [27:0] start;
  } cfg_t;

  // folded angle in turns, plus the half-turn flag
  typedef struct packed {
    logic signed [CW-1:0] z;
    logic                 flip;
  } turn_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/ocp_front.sv */
// Front end: accepts sample times, forms the phase and folds it into turns.
module ocp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [27:0]       sample_time,
  input  ocp_pkg::cfg_t     cfg,
  input  ocp_pkg::qstat_t   q_stat,
  output logic              push,
  output ocp_pkg::turn_t    push_item
);

  logic [3:0]          v;
  logic                en;
  logic signed [28:0]  dt;
  logic signed [53:0]  phase;
  logic signed [53:0]  prod;
  logic [56:0]         pl;
  logic signed [57:0]  ph;
  logic [63:0]         sum64;
  logic [31:0]         zu;
  ocp_pkg::turn_t      fold;
  ocp_pkg::turn_t      tr;

  assign en       = !(v[3] && q_stat.full);
  assign s_tready = en;
  assign push     = v[3] && !q_stat.full;
  assign push_item = tr;

  assign prod  = $signed({1'b0, cfg.rate}) * dt;
  assign sum64 = (64'(ph) << 27) + 64'(pl);
  assign zu    = sum64[63:32];

  always_comb begin
    fold.flip = 1'b0;
    fold.z    = $signed({2'b00, zu});
    priority if (zu >= 32'hC000_0000) begin
      fold.z = $signed({2'b00, zu} - 34'h1_0000_0000);
    end else if (zu >= 32'h4000_0000) begin
      fold.z    = $signed({2'b00, zu} - 34'h0_8000_0000);
      fold.flip = 1'b1;
    end else begin
      fold.z = $signed({2'b00, zu});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt    <= $signed({1'b0, sample_time}) - $signed({1'b0, cfg.start});
      phase <= prod + $signed({18'b0, cfg.angle, 16'b0});
      pl    <= phase[26:0] * ocp_pkg::TURN_PER_RAD;
      ph    <= $signed(phase[53:27]) * $signed({1'b0, ocp_pkg::TURN_PER_RAD});
      tr    <= fold;
    end
  end

endmodule

/* rtl/ocp_queue.sv */
// Short queue between the front end and the back end.
module ocp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ocp_pkg::turn_t    push_item,
  input  logic              pop,
  output ocp_pkg::turn_t    head,
  output ocp_pkg::qstat_t   q_stat
);

  ocp_pkg::turn_t             mem [ocp_pkg::QDEPTH];
  logic [ocp_pkg::QPW-1:0]    wp;
  logic [ocp_pkg::QPW-1:0]    rp;
  logic [ocp_pkg::QCW-1:0]    cnt;
  logic                       do_push;
  logic                       do_pop;

  assign q_stat.full  = (cnt == ocp_pkg::QCW'(ocp_pkg::QDEPTH));
  assign q_stat.empty = (cnt == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count lost a push");

endmodule

/* rtl/ocp_back.sv */
// Back end: CORDIC, radius divider, coordinate multiply and saturation.
module ocp_back (
  input  logic              clk,
  input  logic              rst,
  input  ocp_pkg::cfg_t     cfg,
  input  ocp_pkg::qstat_t   q_stat,
  input  ocp_pkg::turn_t    head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       pos_x,
  output logic [23:0]       pos_y,
  output logic              saturated
);

  localparam int N = ocp_pkg::CORDIC_STEPS;
  localparam int Q = ocp_pkg::QBITS;

  typedef struct packed {
    logic signed [ocp_pkg::CW-1:0] x;
    logic signed [ocp_pkg::CW-1:0] y;
    logic signed [ocp_pkg::CW-1:0] z;
    logic                          flip;
  } rot_t;

  typedef struct packed {
    logic [ocp_pkg::REMW-1:0]  rem;
    logic [Q-1:0]              q;
    logic [ocp_pkg::DENW-1:0]  den;
    logic signed [31:0]        c;
    logic signed [31:0]        s;
  } div_t;

  function automatic rot_t rot_step(rot_t a, int k);
    rot_t                          o;
    logic signed [ocp_pkg::CW-1:0] dx;
    logic signed [ocp_pkg::CW-1:0] dy;
    logic signed [ocp_pkg::CW-1:0] at;
    dx = a.y >>> k;
    dy = a.x >>> k;
    at = $signed({2'b00, ocp_pkg::ATAN_TURNS[k]});
    o  = a;
    if (!a.z[ocp_pkg::CW-1]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - at;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + at;
    end
    return o;
  endfunction

  function automatic logic signed [31:0] clamp_one(logic signed [ocp_pkg::CW-1:0] v);
    logic signed [31:0] o;
    if (v > $signed({{(ocp_pkg::CW-32){1'b0}}, ocp_pkg::ONE_Q30})) o = ocp_pkg::ONE_Q30;
    else if (v < -$signed({{(ocp_pkg::CW-32){1'b0}}, ocp_pkg::ONE_Q30})) o = -ocp_pkg::ONE_Q30;
    else o = v[31:0];
    return o;
  endfunction

  function automatic div_t div_step(div_t a, int b);
    div_t                      o;
    logic [ocp_pkg::SHW-1:0]   dsh;
    dsh = {{(Q-1){1'b0}}, a.den} << b;
    o   = a;
    if ({{(ocp_pkg::SHW-ocp_pkg::REMW){1'b0}}, a.rem} >= dsh) begin
      o.rem  = a.rem - dsh[ocp_pkg::REMW-1:0];
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

  logic en;
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !q_stat.empty;

  // a*(1-e^2) follows the registers on its own; it settles long before use
  logic [31:0]               e2;
  logic [32:0]               kk;
  logic [38:0]               kl;
  logic [37:0]               kh;
  logic [54:0]               ksum;
  logic [ocp_pkg::NUMW-1:0]  num;

  assign kk   = 33'h1_0000_0000 - {1'b0, e2};
  assign ksum = {kh, 17'b0} + 55'(kl);

  always_ff @(posedge clk) begin
    e2  <= cfg.ecc * cfg.ecc;
    kl  <= cfg.sma * kk[16:0];
    kh  <= cfg.sma * kk[32:17];
    num <= ksum[ocp_pkg::NUMW+15:16];
  end

  // CORDIC pipeline, one step per stage
  rot_t cr [N];
  logic [N-1:0] cv;
  rot_t c_in;

  assign c_in = '{x: ocp_pkg::CORDIC_X0, y: '0, z: head.z, flip: head.flip};

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= rot_step(c_in, 0);
      for (int k = 1; k < N; k++) cr[k] <= rot_step(cr[k-1], k);
    end
  end

  // fold back, clamp
  logic signed [ocp_pkg::CW-1:0] xf;
  logic signed [ocp_pkg::CW-1:0] yf;
  logic signed [31:0] pc;
  logic signed [31:0] ps;
  logic               pv;

  assign xf = cr[N-1].flip ? -cr[N-1].x : cr[N-1].x;
  assign yf = cr[N-1].flip ? -cr[N-1].y : cr[N-1].y;

  always_ff @(posedge clk) begin
    if (en) begin
      pc <= clamp_one(xf);
      ps <= clamp_one(yf);
    end
  end

  // denominator 1 + e*cos
  logic signed [48:0]        ec;
  logic signed [48:0]        dsum;
  div_t                      d0;
  logic                      dv;

  assign ec   = $signed({1'b0, cfg.ecc}) * pc;
  assign dsum = 49'sd1073741824 + (ec >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      d0.rem <= {num, 14'b0};
      d0.q   <= '0;
      d0.den <= dsum[ocp_pkg::DENW-1:0];
      d0.c   <= pc;
      d0.s   <= ps;
    end
  end

  // restoring divider, one quotient bit per stage
  div_t         dq [Q];
  logic [Q-1:0] qv;

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0] <= div_step(d0, Q - 1);
      for (int j = 1; j < Q; j++) dq[j] <= div_step(dq[j-1], Q - 1 - j);
    end
  end

  // r*cos and r*sin as two partial products each
  logic signed [51:0] pxl;
  logic signed [51:0] pxh;
  logic signed [51:0] pyl;
  logic signed [51:0] pyh;
  logic               mv;
  logic [Q-1:0]       r;

  assign r = dq[Q-1].q;

  always_ff @(posedge clk) begin
    if (en) begin
      pxl <= $signed({1'b0, r[18:0]}) * dq[Q-1].c;
      pxh <= $signed({1'b0, r[37:19]}) * dq[Q-1].c;
      pyl <= $signed({1'b0, r[18:0]}) * dq[Q-1].s;
      pyh <= $signed({1'b0, r[37:19]}) * dq[Q-1].s;
    end
  end

  logic signed [70:0] fx;
  logic signed [70:0] fy;
  logic signed [70:0] sx;
  logic signed [70:0] sy;
  logic               hx_hi;
  logic               hx_lo;
  logic               hy_hi;
  logic               hy_lo;

  assign fx = (71'(pxh) <<< 19) + 71'(pxl);
  assign fy = (71'(pyh) <<< 19) + 71'(pyl);
  assign sx = fx >>> 30;
  assign sy = fy >>> 30;
  assign hx_hi = sx > ocp_pkg::OUT_MAX;
  assign hx_lo = sx < ocp_pkg::OUT_MIN;
  assign hy_hi = sy > ocp_pkg::OUT_MAX;
  assign hy_lo = sy < ocp_pkg::OUT_MIN;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= hx_hi ? 24'h7F_FFFF : (hx_lo ? 24'h80_0000 : sx[23:0]);
      pos_y <= hy_hi ? 24'h7F_FFFF : (hy_lo ? 24'h80_0000 : sy[23:0]);
      saturated <= hx_hi || hx_lo || hy_hi || hy_lo;
    end
  end

  // item valid chain through the whole back end
  always_ff @(posedge clk) begin
    if (rst) begin
      cv       <= '0;
      pv       <= 1'b0;
      dv       <= 1'b0;
      qv       <= '0;
      mv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      cv[0] <= !q_stat.empty;
      for (int k = 1; k < N; k++) cv[k] <= cv[k-1];
      pv    <= cv[N-1];
      dv    <= pv;
      qv[0] <= dv;
      for (int j = 1; j < Q; j++) qv[j] <= qv[j-1];
      mv       <= qv[Q-1];
      m_tvalid <= mv;
    end
  end

endmodule

/* rtl/conic_orbit_position_core.sv */
// Top level of the conic orbit position core: registers, front, queue, back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: sample_time
//  m_*      out  m_tvalid/m_tready  m_tdata: pos_x, pos_y; m_tuser: saturated
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One item per cycle while m_tready stays high; items pass 4 front stages,
// one queue slot, 18 CORDIC steps, the clamp and denominator registers,
// 38 divider stages (one quotient bit each), then multiply and saturate.
// Reset clears valid state and loads the configuration defaults.
// The back end stalls as a whole when the output register is held; the front
// keeps taking items until the 4-entry queue fills.
module conic_orbit_position_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [27:0] sample_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] pos_x, [47:24] pos_y
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [27:0] cfg_data
);

  ocp_pkg::cfg_t    cfg;
  ocp_pkg::qstat_t  q_stat;
  ocp_pkg::turn_t   push_item;
  ocp_pkg::turn_t   head;
  logic             push;
  logic             pop;
  logic [23:0]      pos_x;
  logic [23:0]      pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sma   <= 22'd65536;
      cfg.ecc   <= '0;
      cfg.rate  <= '0;
      cfg.angle <= '0;
      cfg.start <= '0;
    end else if (cfg_we) begin
      unique case (ocp_pkg::cfg_reg_t'(cfg_index))
        ocp_pkg::REG_SMA:   cfg.sma   <= cfg_data[21:0];
        ocp_pkg::REG_ECC:   cfg.ecc   <= cfg_data[15:0];
        ocp_pkg::REG_RATE:  cfg.rate  <= cfg_data[23:0];
        ocp_pkg::REG_ANGLE: cfg.angle <= cfg_data[18:0];
        ocp_pkg::REG_START: cfg.start <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  ocp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .sample_time (s_tdata[27:0]),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .push        (push),
    .push_item   (push_item)
  );

  ocp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ocp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .saturated (m_tuser)
  );

  assign m_tdata = {pos_y, pos_x};

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the conic orbit position core: directed table, then random items.
module tb_top;

  localparam int LAT_WAIT = 90;    // cycles allowed for the pipeline to empty
  localparam int DOG_LIMIT = 3000;
  localparam logic [2:0] REG_BAD = 3'd7;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               sat;
  } pos_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [27:0] val;
    bit          typed;   // saturated flag is known to be clear
  } dir_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [27:0] cfg_data = '0;

  conic_orbit_position_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // configuration copy for the predictor
  logic [21:0] sma_r = 22'd65536;
  logic [15:0] ecc_r = '0;
  logic [23:0] rate_r = '0;
  logic [18:0] angle_r = '0;
  logic [27:0] start_r = '0;

  pos_t pos_q [$];
  bit   failed = 0;
  int   sent_cnt = 0;
  int   accept_cnt = 0;
  int   typed_idx = -1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   dog = 0;

  function automatic pos_t orbit_position(logic [27:0] st);
    longint dt, ph, z, c, s, dx, dy, e, den, xv, yv;
    longint unsigned tr, num, r;
    bit flip;
    pos_t p;
    flip = 0;
    p.sat = 0;
    dt = longint'(st) - longint'(start_r);
    ph = longint'(rate_r) * dt + (longint'(angle_r) <<< 16);
    tr = longint'(ph) * 64'd683565276;
    z = longint'(tr >> 32);
    if (z >= 64'sd3221225472) z = z - 64'sd4294967296;
    else if (z >= 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1;
    end
    c = 64'sd652032874;
    s = 0;
    for (int i = 0; i < ocp_pkg::CORDIC_STEPS; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (z >= 0) begin
        c = c - dx; s = s + dy; z = z - longint'(ocp_pkg::ATAN_TURNS[i]);
      end else begin
        c = c + dx; s = s - dy; z = z + longint'(ocp_pkg::ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      c = -c; s = -s;
    end
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    if (c < -64'sd1073741824) c = -64'sd1073741824;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    e = longint'(ecc_r);
    num = (longint'(sma_r) * (64'sd4294967296 - e * e)) >> 16;
    den = 64'sd1073741824 + ((e * c) >>> 16);
    if (den < 1) den = 1;
    r = (num << 14) / longint'(den);
    xv = (longint'(r) * c) >>> 30;
    yv = (longint'(r) * s) >>> 30;
    if (xv > 64'sd8388607) begin xv = 64'sd8388607; p.sat = 1; end
    if (xv < -64'sd8388608) begin xv = -64'sd8388608; p.sat = 1; end
    if (yv > 64'sd8388607) begin yv = 64'sd8388607; p.sat = 1; end
    if (yv < -64'sd8388608) begin yv = -64'sd8388608; p.sat = 1; end
    p.x = xv[23:0];
    p.y = yv[23:0];
    return p;
  endfunction

  // predict on accept, check on result, watchdog
  always @(posedge clk) begin
    pos_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = orbit_position(s_tdata[27:0]);
        if (accept_cnt == typed_idx) want.sat = 1'b0;
        pos_q.insert(pos_q.size(), want);
        accept_cnt <= accept_cnt + 1;
      end
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[23:0];
        got.y = m_tdata[47:24];
        got.sat = m_tuser;
        if (pos_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", got.x, got.y);
          failed = 1;
        end else begin
          want = pos_q.pop_front();
          if (got.x !== want.x) begin
            $error("pos_x expected %0d got %0d", want.x, got.x); failed = 1;
          end
          if (got.y !== want.y) begin
            $error("pos_y expected %0d got %0d", want.y, got.y); failed = 1;
          end
          if (got.sat !== want.sat) begin
            $error("saturated expected %0d got %0d", want.sat, got.sat); failed = 1;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          !(s_tvalid || pos_q.size() > 0))
        dog <= 0;
      else
        dog <= dog + 1;
      if (dog >= DOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_sample(logic [27:0] st);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'd0, st};
    sent_cnt++;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pos_q.size() > 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  // one write per call, enable dropped again before the task returns
  task automatic write_reg(logic [2:0] idx, logic [27:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ocp_pkg::REG_SMA:   sma_r = val[21:0];
      ocp_pkg::REG_ECC:   ecc_r = val[15:0];
      ocp_pkg::REG_RATE:  rate_r = val[23:0];
      ocp_pkg::REG_ANGLE: angle_r = val[18:0];
      ocp_pkg::REG_START: start_r = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  dir_row_t dir_tab [24] = '{
    '{0, ocp_pkg::REG_SMA, 28'd0, 1},            // reset settings, one AU circle
    '{0, ocp_pkg::REG_SMA, 28'hFFFFFFF, 0},
    '{1, ocp_pkg::REG_RATE, 28'hFFFFFF, 0},
    '{0, ocp_pkg::REG_SMA, 28'd0, 0},
    '{0, ocp_pkg::REG_SMA, 28'hFFFFFFF, 0},
    '{1, ocp_pkg::REG_START, 28'hFFFFFFF, 0},    // samples before the start time
    '{0, ocp_pkg::REG_SMA, 28'd0, 0},
    '{0, ocp_pkg::REG_SMA, 28'd12345, 0},
    '{1, ocp_pkg::REG_ANGLE, 28'd411774, 0},     // start angle just short of a full turn
    '{0, ocp_pkg::REG_SMA, 28'd0, 0},
    '{1, ocp_pkg::REG_ECC, 28'hFFFF, 0},         // eccentricity next to one
    '{1, ocp_pkg::REG_SMA, 28'h3FFFFF, 0},
    '{1, ocp_pkg::REG_RATE, 28'd0, 0},
    '{1, ocp_pkg::REG_ANGLE, 28'd205887, 0},     // aphelion, radius near its top
    '{0, ocp_pkg::REG_SMA, 28'd5, 0},
    '{1, ocp_pkg::REG_ANGLE, 28'd0, 0},
    '{0, ocp_pkg::REG_SMA, 28'd0, 0},
    '{1, REG_BAD, 28'hFFFFFFF, 0},               // ignored write
    '{0, ocp_pkg::REG_SMA, 28'd9, 0},
    '{1, ocp_pkg::REG_SMA, 28'd0, 0},
    '{0, ocp_pkg::REG_SMA, 28'd77, 0},
    '{1, ocp_pkg::REG_ECC, 28'd0, 0},
    '{1, ocp_pkg::REG_SMA, 28'd65536, 0},
    '{0, ocp_pkg::REG_SMA, 28'd100, 0}
  };

  initial begin
    logic [27:0] st;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (dir_tab[i].typed) typed_idx = sent_cnt;
        send_sample(dir_tab[i].val);
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();   // sender holds off until every result is back
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      write_reg(ocp_pkg::REG_SMA, (p == 3) ? 28'h3FFFFF : ($urandom_range(3) == 0 ?
                28'($urandom) : 28'($urandom_range(22'h7FFFF))));
      write_reg(ocp_pkg::REG_ECC, (p == 5) ? 28'hFFFF : 28'($urandom));
      write_reg(ocp_pkg::REG_RATE, (p == 6) ? 28'hFFFFFF : 28'($urandom));
      write_reg(ocp_pkg::REG_ANGLE,
                (p == 7) ? 28'd411774 : 28'($urandom_range(411774)));
      write_reg(ocp_pkg::REG_START, 28'($urandom));
      if (p == 4) write_reg(REG_BAD, 28'($urandom));
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(3) == 0) st = start_r + 28'($urandom_range(4095)) - 28'd2048;
        else st = 28'($urandom);
        send_sample(st);
      end
    end

    drain();
    if (!failed && pos_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/ocp_pkg.sv
rtl/ocp_front.sv
rtl/ocp_queue.sv
rtl/ocp_back.sv
rtl/conic_orbit_position_core.sv
tb/sv/tb_top.sv
